@@ src/bal_pkg.sv @@
// ----------------------------------------------------------------------------
// bal_pkg
// Types and constants shared by the bounded array list core and its cells.
// ----------------------------------------------------------------------------
package bal_pkg;

    localparam int DEF_CAPACITY = 32;
    localparam logic [5:0] CAP_LIMIT_RST = 6'd20;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_BACK   = 3'd2,
        CMD_POP_FRONT  = 3'd3,
        CMD_INSERT     = 3'd4,
        CMD_READ       = 3'd5,
        CMD_WRITE      = 3'd6,
        CMD_FILL       = 3'd7
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_cmd               cmd;
        logic [5:0]         position;
        logic signed [31:0] value;
    } t_req;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [5:0]         count;
        t_status            status;
    } t_rsp;

    typedef struct packed {
        logic       load;
        logic [5:0] load_pos;
        logic       shift_up;
        logic       shift_dn;
        logic [5:0] lo;
        logic [5:0] hi;
        logic       fill;
        logic [5:0] cap;
    } t_cell_ctl;

endpackage

@@ src/bal_cell.sv @@
// ----------------------------------------------------------------------------
// bal_cell
// One list entry: loads the command value or takes a neighbor's entry.
// ----------------------------------------------------------------------------
module bal_cell
    import bal_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cell_ctl          i_ctl,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_left,
    input  logic signed [31:0] i_right,
    output logic signed [31:0] o_data
);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    always_comb begin
        n_data = r_data;
        if (i_ctl.fill && (IDX < int'(i_ctl.cap))) begin
            n_data = i_value;
        end else if (i_ctl.load && (IDX == int'(i_ctl.load_pos))) begin
            n_data = i_value;
        end else if (i_ctl.shift_up && (IDX > int'(i_ctl.lo)) && (IDX <= int'(i_ctl.hi))) begin
            n_data = i_left;
        end else if (i_ctl.shift_dn && (IDX >= int'(i_ctl.lo)) && (IDX < int'(i_ctl.hi))) begin
            n_data = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_data <= '0;
        end else begin
            r_data <= n_data;
        end
    end

    assign o_data = r_data;

endmodule

@@ src/bounded_array_list_core.sv @@
// ----------------------------------------------------------------------------
// bounded_array_list_core
// Bounded packed list of signed 32-bit entries held in a row of shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive i_req and pulse start; a transaction is taken at
//   each rising edge with start high and busy low. busy stays low, so one
//   command may follow another in every cycle.
//   Result channel: o_rsp is valid for one cycle with o_strobe high, the
//   cycle after the command is taken (throughput 1 per cycle).
//   Each cell moves its entry to a neighbor in the same cycle, so shifts for
//   push_front, pop_front and insert are done at the edge that takes the command.
//   The receiver cannot stall; every result must be taken when strobed.
//   Configuration: write the capacity limit on i_cfg_data with i_cfg_valid;
//   o_cfg_ready is low only while a command is taken. Lowering the limit
//   clips the count. Write it only while no command is in flight.
//   Reset: synchronous, active low; all entries clear to zero, the count to
//   zero and the capacity limit to 20. No command result is pending after.
// ----------------------------------------------------------------------------
module bounded_array_list_core
    import bal_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_strobe,
    output t_rsp       o_rsp,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_cfg_data
);

    localparam int CAP_CLIP = (CAPACITY > 63) ? 63 : CAPACITY;

    logic [5:0]         r_cap_limit;
    logic [5:0]         r_count;
    logic [5:0]         n_count;
    logic               r_strobe;
    t_rsp               r_rsp;
    t_rsp               n_rsp;
    t_cell_ctl          cell_ctl;
    logic [5:0]         cap_eff;
    logic [5:0]         cfg_cap;
    logic [5:0]         ins_pos;
    logic               cmd_go;
    logic signed [31:0] tap;
    logic signed [31:0] cell_data [CAPACITY];

    function automatic logic [5:0] eff_cap(input logic [5:0] limit);
        logic [5:0] res;
        if (limit == 6'd0) begin
            res = 6'd1;
        end else if (int'(limit) > CAP_CLIP) begin
            res = 6'(CAP_CLIP);
        end else begin
            res = limit;
        end
        return res;
    endfunction

    assign busy        = 1'b0;
    assign cmd_go      = start && !busy;
    assign o_cfg_ready = !cmd_go;
    assign cap_eff     = eff_cap(r_cap_limit);
    assign cfg_cap     = eff_cap(i_cfg_data);
    assign ins_pos     = (i_req.position > r_count) ? r_count : i_req.position;

    always_comb begin
        tap = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == int'(i_req.position)) begin
                tap = cell_data[i];
            end
        end
    end

    always_comb begin
        cell_ctl          = '0;
        cell_ctl.cap      = cap_eff;
        n_count           = r_count;
        n_rsp.read_value  = '0;
        n_rsp.status      = ST_OK;
        case (i_req.cmd)
            CMD_PUSH_BACK: begin
                if (r_count >= cap_eff) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    cell_ctl.load     = cmd_go;
                    cell_ctl.load_pos = r_count;
                    n_count           = r_count + 6'd1;
                end
            end
            CMD_PUSH_FRONT: begin
                if (r_count >= cap_eff) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    cell_ctl.load     = cmd_go;
                    cell_ctl.load_pos = 6'd0;
                    cell_ctl.shift_up = cmd_go;
                    cell_ctl.lo       = 6'd0;
                    cell_ctl.hi       = r_count;
                    n_count           = r_count + 6'd1;
                end
            end
            CMD_POP_BACK: begin
                if (r_count == 6'd0) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_count = r_count - 6'd1;
                end
            end
            CMD_POP_FRONT: begin
                if (r_count == 6'd0) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    cell_ctl.shift_dn = cmd_go;
                    cell_ctl.lo       = 6'd0;
                    cell_ctl.hi       = r_count - 6'd1;
                    n_count           = r_count - 6'd1;
                end
            end
            CMD_INSERT: begin
                if (r_count >= cap_eff) begin
                    n_rsp.status = ST_FULL;
                end else begin
                    cell_ctl.load     = cmd_go;
                    cell_ctl.load_pos = ins_pos;
                    cell_ctl.shift_up = cmd_go;
                    cell_ctl.lo       = ins_pos;
                    cell_ctl.hi       = r_count;
                    n_count           = r_count + 6'd1;
                end
            end
            CMD_READ: begin
                if (i_req.position >= cap_eff) begin
                    n_rsp.status = ST_RANGE;
                end else begin
                    n_rsp.read_value = tap;
                end
            end
            CMD_WRITE: begin
                if (i_req.position >= cap_eff) begin
                    n_rsp.status = ST_RANGE;
                end else begin
                    cell_ctl.load     = cmd_go;
                    cell_ctl.load_pos = i_req.position;
                end
            end
            CMD_FILL: begin
                cell_ctl.fill = cmd_go;
                n_count       = cap_eff;
            end
            default: begin
                n_rsp.status = ST_OK;
            end
        endcase
        n_rsp.count = n_count;
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [31:0] left;
        logic signed [31:0] right;
        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_data[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_data[g+1];
        end
        bal_cell #(
            .IDX(g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (cell_ctl),
            .i_value(i_req.value),
            .i_left (left),
            .i_right(right),
            .o_data (cell_data[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap_limit <= CAP_LIMIT_RST;
            r_count     <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_strobe <= cmd_go;
            if (cmd_go) begin
                r_count <= n_count;
            end else if (i_cfg_valid && o_cfg_ready) begin
                r_cap_limit <= i_cfg_data;
                if (r_count > cfg_cap) begin
                    r_count <= cfg_cap;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd_go) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

@@ dv/bounded_array_list_core_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_array_list_core_tb
// Self-checking bench for the bounded array list core. A short table of
// directed commands covers the empty, full and out-of-range cases, the field
// extremes and every command. Random grow and shrink bursts follow under
// several capacity limits, among them zero, one and values above the array
// size. Each result is checked against a cycle-free list model or a pinned value.
// ----------------------------------------------------------------------------
module bounded_array_list_core_tb;
    import bal_pkg::*;

    typedef struct packed {
        t_req    req;
        logic    pinned;
        t_rsp    rsp;
    } t_cmd_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    t_req       i_req;
    logic       o_strobe;
    t_rsp       o_rsp;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [5:0] i_cfg_data;

    logic signed [31:0] list_entries [DEF_CAPACITY];
    int                 list_count;
    logic [5:0]         cap_limit;

    t_rsp     rsp_expected_q [$];
    t_cmd_row directed_rows [$];

    int mismatch_cnt = 0;
    int checked_cnt  = 0;
    int cfg_writes   = 0;
    int cmd_hits    [8];
    int status_hits [4];

    bounded_array_list_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_strobe    (o_strobe),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    function automatic int usable_cap();
        if (cap_limit == 6'd0) begin
            return 1;
        end
        if (int'(cap_limit) > DEF_CAPACITY) begin
            return DEF_CAPACITY;
        end
        return int'(cap_limit);
    endfunction

    function automatic t_rsp list_exec(input t_req r);
        t_rsp rsp;
        int   cap;
        int   pos;
        cap = usable_cap();
        pos = int'(r.position);
        rsp.read_value = '0;
        rsp.status = ST_OK;
        if (list_count > cap) begin
            list_count = cap;
        end
        case (r.cmd)
            CMD_PUSH_BACK: begin
                if (list_count >= cap) begin
                    rsp.status = ST_FULL;
                end else begin
                    list_entries[list_count] = r.value;
                    list_count++;
                end
            end
            CMD_PUSH_FRONT: begin
                if (list_count >= cap) begin
                    rsp.status = ST_FULL;
                end else begin
                    for (int i = list_count; i > 0; i--) list_entries[i] = list_entries[i-1];
                    list_entries[0] = r.value;
                    list_count++;
                end
            end
            CMD_POP_BACK: begin
                if (list_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    list_count--;
                end
            end
            CMD_POP_FRONT: begin
                if (list_count == 0) begin
                    rsp.status = ST_EMPTY;
                end else begin
                    for (int i = 0; i + 1 < list_count; i++) list_entries[i] = list_entries[i+1];
                    list_count--;
                end
            end
            CMD_INSERT: begin
                if (list_count >= cap) begin
                    rsp.status = ST_FULL;
                end else begin
                    if (pos > list_count) pos = list_count;
                    for (int i = list_count; i > pos; i--) list_entries[i] = list_entries[i-1];
                    list_entries[pos] = r.value;
                    list_count++;
                end
            end
            CMD_READ: begin
                if (pos >= cap) begin
                    rsp.status = ST_RANGE;
                end else begin
                    rsp.read_value = list_entries[pos];
                end
            end
            CMD_WRITE: begin
                if (pos >= cap) begin
                    rsp.status = ST_RANGE;
                end else begin
                    list_entries[pos] = r.value;
                end
            end
            default: begin
                for (int i = 0; i < cap; i++) list_entries[i] = r.value;
                list_count = cap;
            end
        endcase
        rsp.count = list_count[5:0];
        return rsp;
    endfunction

    function automatic t_cmd_row plain_row(t_cmd c, logic [5:0] p, logic [31:0] v);
        t_cmd_row row;
        row.req.cmd = c;
        row.req.position = p;
        row.req.value = v;
        row.pinned = 1'b0;
        row.rsp = '0;
        return row;
    endfunction

    function automatic t_cmd_row pinned_row(t_cmd c, logic [5:0] p, logic [31:0] v,
                                            logic [31:0] rv, logic [5:0] cnt, t_status st);
        t_cmd_row row;
        row = plain_row(c, p, v);
        row.pinned = 1'b1;
        row.rsp.read_value = rv;
        row.rsp.count = cnt;
        row.rsp.status = st;
        return row;
    endfunction

    function automatic int gap_len(input bit calm);
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 60) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // Call at a falling edge; returns at a falling edge.
    task automatic issue(input t_cmd_row row, input int gap);
        t_rsp predicted;
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req = row.req;
        start = 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        predicted = list_exec(row.req);
        rsp_expected_q.push_back(row.pinned ? row.rsp : predicted);
        cmd_hits[row.req.cmd]++;
        status_hits[predicted.status]++;
        @(negedge i_clk);
    endtask

    task automatic write_cap(input logic [5:0] limit);
        start = 1'b0;
        while (rsp_expected_q.size() != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
        i_cfg_data = limit;
        i_cfg_valid = 1'b1;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        cap_limit = limit;
        if (list_count > usable_cap()) list_count = usable_cap();
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    always @(posedge i_clk) begin : rsp_check
        t_rsp want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (rsp_expected_q.size() == 0) begin
                $error("result with no command pending: read_value %h count %0d status %0d",
                       o_rsp.read_value, o_rsp.count, o_rsp.status);
                mismatch_cnt++;
            end else begin
                want = rsp_expected_q.pop_front();
                checked_cnt++;
                if (o_rsp.read_value !== want.read_value) begin
                    $error("read_value: expected %h, actual %h", want.read_value,
                           o_rsp.read_value);
                    mismatch_cnt++;
                end
                if (o_rsp.count !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, o_rsp.count);
                    mismatch_cnt++;
                end
                if (o_rsp.status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_rsp.status);
                    mismatch_cnt++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", rsp_expected_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int         cfg_plan [6] = '{7, 0, 63, 1, 32, 2};
        logic [5:0] limit;
        bit         grow;
        bit         calm;
        int         roll;
        int         cap;
        t_cmd       c;
        logic [5:0] p;
        logic [31:0] v;
        int         wait_cycles;

        for (int i = 0; i < DEF_CAPACITY; i++) list_entries[i] = '0;
        list_count = 0;
        cap_limit = CAP_LIMIT_RST;
        for (int i = 0; i < 8; i++) cmd_hits[i] = 0;
        for (int i = 0; i < 4; i++) status_hits[i] = 0;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_req = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        directed_rows.push_back(pinned_row(CMD_POP_BACK, 6'd0, 32'h0, 32'h0, 6'd0, ST_EMPTY));
        directed_rows.push_back(pinned_row(CMD_POP_FRONT, 6'd0, 32'h0, 32'h0, 6'd0, ST_EMPTY));
        directed_rows.push_back(pinned_row(CMD_READ, 6'd0, 32'h0, 32'h0, 6'd0, ST_OK));
        directed_rows.push_back(pinned_row(CMD_READ, 6'd63, 32'h0, 32'h0, 6'd0, ST_RANGE));
        directed_rows.push_back(pinned_row(CMD_WRITE, 6'd20, 32'hdeadbeef, 32'h0, 6'd0,
                                           ST_RANGE));
        directed_rows.push_back(plain_row(CMD_PUSH_BACK, 6'd0, 32'h7fffffff));
        directed_rows.push_back(plain_row(CMD_PUSH_FRONT, 6'd63, 32'h80000000));
        directed_rows.push_back(plain_row(CMD_INSERT, 6'd1, 32'hffffffff));
        directed_rows.push_back(plain_row(CMD_INSERT, 6'd63, 32'h55555555));
        directed_rows.push_back(plain_row(CMD_READ, 6'd0, 32'h0));
        directed_rows.push_back(plain_row(CMD_READ, 6'd1, 32'h0));
        directed_rows.push_back(plain_row(CMD_READ, 6'd2, 32'h0));
        directed_rows.push_back(plain_row(CMD_READ, 6'd3, 32'h0));
        directed_rows.push_back(plain_row(CMD_WRITE, 6'd19, 32'haaaaaaaa));
        directed_rows.push_back(plain_row(CMD_READ, 6'd19, 32'h0));
        directed_rows.push_back(plain_row(CMD_READ, 6'd4, 32'h0));
        directed_rows.push_back(plain_row(CMD_POP_FRONT, 6'd0, 32'h0));
        directed_rows.push_back(plain_row(CMD_POP_BACK, 6'd0, 32'h0));
        directed_rows.push_back(pinned_row(CMD_FILL, 6'd0, 32'h12345678, 32'h0, 6'd20, ST_OK));
        directed_rows.push_back(pinned_row(CMD_PUSH_BACK, 6'd0, 32'h1, 32'h0, 6'd20, ST_FULL));
        directed_rows.push_back(pinned_row(CMD_PUSH_FRONT, 6'd0, 32'h2, 32'h0, 6'd20, ST_FULL));
        directed_rows.push_back(pinned_row(CMD_INSERT, 6'd0, 32'h3, 32'h0, 6'd20, ST_FULL));
        directed_rows.push_back(plain_row(CMD_WRITE, 6'd0, 32'h0));
        directed_rows.push_back(plain_row(CMD_POP_BACK, 6'd0, 32'h0));
        directed_rows.push_back(plain_row(CMD_READ, 6'd19, 32'h0));

        foreach (directed_rows[k]) issue(directed_rows[k], gap_len(1'b0));

        grow = 1'b1;
        calm = 1'b0;
        for (int ph = 0; ph < 12; ph++) begin
            limit = (ph < 6) ? 6'(cfg_plan[ph]) : 6'($urandom_range(0, 63));
            write_cap(limit);
            for (int n = 0; n < 148; n++) begin
                if (n % 20 == 0) begin
                    grow = ($urandom_range(0, 99) < 55);
                    calm = ($urandom_range(0, 3) == 0);
                end
                cap = usable_cap();
                roll = $urandom_range(0, 99);
                if (roll < (grow ? 60 : 20)) begin
                    case ($urandom_range(0, 2))
                        0: c = CMD_PUSH_BACK;
                        1: c = CMD_PUSH_FRONT;
                        default: c = CMD_INSERT;
                    endcase
                end else if (roll < (grow ? 75 : 70)) begin
                    c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
                end else if (roll < (grow ? 97 : 97)) begin
                    c = $urandom_range(0, 1) ? CMD_READ : CMD_WRITE;
                end else begin
                    c = CMD_FILL;
                end
                if ($urandom_range(0, 3) != 0) begin
                    p = 6'($urandom_range(0, cap));
                end else begin
                    p = 6'($urandom_range(0, 63));
                end
                if ($urandom_range(0, 9) == 0) begin
                    case ($urandom_range(0, 3))
                        0: v = 32'h0;
                        1: v = 32'hffffffff;
                        2: v = 32'h7fffffff;
                        default: v = 32'h80000000;
                    endcase
                end else begin
                    v = $urandom;
                end
                issue(plain_row(c, p, v), gap_len(calm));
            end
        end

        start = 1'b0;
        wait_cycles = 0;
        while (rsp_expected_q.size() != 0 && wait_cycles < 1000) begin
            @(negedge i_clk);
            wait_cycles++;
        end
        repeat (4) @(negedge i_clk);
        if (rsp_expected_q.size() != 0) begin
            $error("%0d expected results never arrived", rsp_expected_q.size());
            mismatch_cnt++;
        end

        $display("commands sent: push_back %0d, push_front %0d, pop_back %0d, pop_front %0d, %s",
                 cmd_hits[CMD_PUSH_BACK], cmd_hits[CMD_PUSH_FRONT], cmd_hits[CMD_POP_BACK],
                 cmd_hits[CMD_POP_FRONT], $sformatf("insert %0d, read %0d, write %0d, fill %0d",
                 cmd_hits[CMD_INSERT], cmd_hits[CMD_READ], cmd_hits[CMD_WRITE],
                 cmd_hits[CMD_FILL]));
        $display("%0d results compared (%0d full, %0d empty, %0d out of range), %0d limit writes",
                 checked_cnt, status_hits[ST_FULL], status_hits[ST_EMPTY],
                 status_hits[ST_RANGE], cfg_writes);
        if (mismatch_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
